// ----- rtl/ebc_pkg.sv -----
// Package: shared types, constants and state codes for the binomial coefficient block.
`default_nettype none
package ebc_pkg;
   localparam int WordBits = 64;

   typedef struct packed {
      logic [WordBits-1:0] n;
      logic [WordBits-1:0] k;
   } req_type;

   typedef struct packed {
      logic [WordBits-1:0] coefficient;
      logic                overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;       // capture a new item and classify it
      logic mul_start;  // begin the checked multiply of one step
      logic div_start;  // begin the exact division of one step
      logic rsp_take;   // result item was taken
   } cmd_type;

   typedef struct packed {
      logic trivial;    // result known without stepping
      logic last_step;  // j equals the step count
      logic mul_done;
      logic mul_ovf;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/exact_binomial_coefficient_top.sv -----
// Top level: binomial coefficient C(n,k) with valid/ready item channels.
`default_nettype none
// Computes C(n,k) over 64-bit unsigned words, one item at a time. An item with
// k>n, k=0 or k=n goes from setup straight to the result. Otherwise min(k,n-k)
// steps run, each a shift-add multiply over all 64 multiplier bits (overflow
// checked every bit) and a restoring divide by the step index; overflow ends
// the run by step 65, and a finished item then waits for any result stall.
// Overflow yields coefficient 0 with overflow set.
// A new item is taken only after the previous result item is delivered.
module exact_binomial_coefficient_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire ebc_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      ebc_pkg::rsp_type rsp_data
);
   import ebc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ebc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   ebc_datapath u_dp (
      .clock, .req_data, .cmd, .sts, .rsp_data
   );
endmodule
`default_nettype wire

// ----- rtl/ebc_ctrl.sv -----
// Controller: sequences setup, multiply and divide phases of each item.
`default_nettype none
module ebc_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire ebc_pkg::sts_type sts,
   output      ebc_pkg::cmd_type cmd
);
   import ebc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SETUP;
         ST_SETUP: state_in = sts.trivial ? ST_DONE : ST_MUL;
         ST_MUL: begin
            if (sts.mul_done) state_in = sts.mul_ovf ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = sts.last_step ? ST_DONE : ST_MUL;
         end
         ST_DONE:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = (state_ff == ST_DONE);
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.mul_start = ((state_ff == ST_SETUP) && !sts.trivial) ||
                      ((state_ff == ST_DIV) && sts.div_done && !sts.last_step);
      cmd.div_start = (state_ff == ST_MUL) && sts.mul_done && !sts.mul_ovf;
      cmd.rsp_take  = (state_ff == ST_DONE) && rsp_ready;
   end

   a_start_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mul_start && cmd.div_start))
      else $error("multiply and divide started together");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before taken");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_SETUP)
      else $error("load did not enter setup");
endmodule
`default_nettype wire

// ----- rtl/ebc_datapath.sv -----
// Datapath: operand registers, shift-add checked multiplier, restoring divider.
`default_nettype none
module ebc_datapath (
   input  wire logic             clock,
   input  wire ebc_pkg::req_type req_data,
   input  wire ebc_pkg::cmd_type cmd,
   output      ebc_pkg::sts_type sts,
   output      ebc_pkg::rsp_type rsp_data
);
   import ebc_pkg::*;

   localparam int CntBits = $clog2(WordBits + 1);

   logic [WordBits-1:0] n_ff, n_in;
   logic [WordBits-1:0] steps_ff, steps_in;
   logic [WordBits-1:0] j_ff, j_in;
   logic [WordBits-1:0] val_ff, val_in;
   logic [WordBits-1:0] factor_ff, factor_in;
   logic [WordBits-1:0] rem_ff, rem_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                trivial_ff, trivial_in;
   logic                ovf_ff, ovf_in;
   logic                mul_busy_ff, mul_busy_in;
   logic                div_busy_ff, div_busy_in;

   logic [WordBits-1:0] nmk;
   logic                k_gt_n;
   logic [WordBits:0]   acc_sum;
   logic [WordBits:0]   rem_shift;
   logic [WordBits:0]   rem_diff;
   logic                cnt_last;

   assign nmk       = req_data.n - req_data.k;
   assign k_gt_n    = req_data.k > req_data.n;
   assign cnt_last  = (cnt_ff == CntBits'(WordBits - 1));
   // multiply: val_ff is the running product, factor_ff is shifted multiplier, rem_ff multiplicand
   assign acc_sum   = {1'b0, val_ff} + {1'b0, rem_ff};
   // divide: rem_ff remainder, val_ff dividend shifting into quotient
   assign rem_shift = {rem_ff, val_ff[WordBits-1]};
   assign rem_diff  = rem_shift - {1'b0, j_ff};

   always_comb begin
      n_in = n_ff; steps_in = steps_ff; j_in = j_ff; val_in = val_ff;
      factor_in = factor_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      trivial_in = trivial_ff; ovf_in = ovf_ff;
      mul_busy_in = mul_busy_ff; div_busy_in = div_busy_ff;
      if (cmd.load) begin
         n_in        = req_data.n;
         steps_in    = (req_data.k > nmk) ? nmk : req_data.k;
         trivial_in  = k_gt_n || req_data.k == '0 || req_data.k == req_data.n;
         val_in      = k_gt_n ? '0 : WordBits'(1);
         j_in        = WordBits'(1);
         ovf_in      = 1'b0;
         mul_busy_in = 1'b0;
         div_busy_in = 1'b0;
      end else if (mul_busy_ff) begin
         if (factor_ff[0]) begin
            val_in = acc_sum[WordBits-1:0];
            if (acc_sum[WordBits]) ovf_in = 1'b1;
         end
         if (factor_ff[WordBits-1:1] != '0 && rem_ff[WordBits-1]) ovf_in = 1'b1;
         rem_in    = rem_ff << 1;
         factor_in = factor_ff >> 1;
         cnt_in    = cnt_ff + CntBits'(1);
         if (cnt_last) mul_busy_in = 1'b0;
      end else if (div_busy_ff) begin
         if (!rem_diff[WordBits]) begin
            rem_in = rem_diff[WordBits-1:0];
            val_in = {val_ff[WordBits-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[WordBits-1:0];
            val_in = {val_ff[WordBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CntBits'(1);
         if (cnt_last) begin
            div_busy_in = 1'b0;
         end
      end else if (cmd.rsp_take) begin
         ovf_in = 1'b0;
      end
      // advance j once the step's division retires
      if (div_busy_ff && cnt_last) j_in = j_ff + WordBits'(1);
      // start the next phase off the values the retiring phase leaves behind
      if (cmd.mul_start) begin
         // multiplicand = current val, multiplier = n-(j-1); accumulate LSB first
         rem_in      = val_in;
         factor_in   = n_ff - (j_in - WordBits'(1));
         val_in      = '0;
         cnt_in      = '0;
         mul_busy_in = 1'b1;
      end
      if (cmd.div_start) begin
         rem_in      = '0;
         cnt_in      = '0;
         div_busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; steps_ff <= steps_in; j_ff <= j_in; val_ff <= val_in;
      factor_ff <= factor_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      trivial_ff <= trivial_in; ovf_ff <= ovf_in;
      mul_busy_ff <= mul_busy_in; div_busy_ff <= div_busy_in;
   end

   assign sts.trivial   = trivial_ff;
   assign sts.last_step = (j_ff == steps_ff);
   assign sts.mul_done  = mul_busy_ff && cnt_last;
   // overflow check includes the final add of this cycle
   assign sts.mul_ovf   = ovf_ff || (factor_ff[0] && acc_sum[WordBits]);
   assign sts.div_done  = div_busy_ff && cnt_last;

   assign rsp_data.coefficient = ovf_ff ? '0 : val_ff;
   assign rsp_data.overflow    = ovf_ff;
endmodule
`default_nettype wire
